FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int CODE_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int POS_W    = 11;
    localparam int CELL_W   = CODE_W + ATTR_W;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT_CHAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT_AT   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd2;

    // character and attribute constants
    localparam logic [CODE_W-1:0] NEWLINE_CODE     = 8'h0A;
    localparam logic [CODE_W-1:0] SPACE_CODE       = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_RESET      = 16'h0F20;
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY_RD,
        S_COPY_WR,
        S_FILL,
        S_DONE
    } tcw_state_t;

endpackage

FILE: rtl/core/tcw_if.sv
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CODE_W-1:0]   char_code;
    logic [ATTR_W-1:0]   cell_color;
    logic [COL_IN_W-1:0] column;
    logic [ROW_IN_W-1:0] row;

    modport source (
        output valid, func, char_code, cell_color, column, row,
        input  ready
    );

    modport sink (
        input  valid, func, char_code, cell_color, column, row,
        output ready
    );
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    cursor_position;
    logic [ROW_IN_W-1:0] cursor_row;
    logic [COL_IN_W-1:0] cursor_col;
    logic [CELL_W-1:0]   cell_data;
    logic                scrolled;

    modport source (
        output valid, cursor_position, cursor_row, cursor_col, cell_data, scrolled,
        input  ready
    );

    modport sink (
        input  valid, cursor_position, cursor_row, cursor_col, cell_data, scrolled,
        output ready
    );
endinterface

FILE: rtl/core/tcw_screen_ram.sv
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] screen_mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            screen_mem[waddr] <= wdata;
        end
        rdata_reg <= screen_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tcw_seq.sv
module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data,
    tcw_cmd_if.sink                    cmd,
    tcw_rsp_if.source                  rsp,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]          mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PW     = (ADDR_W > POS_W) ? ADDR_W : POS_W;
    localparam int RW     = (ROW_W > ROW_IN_W) ? ROW_W : ROW_IN_W;
    localparam int CW     = (COL_W > COL_IN_W) ? COL_W : COL_IN_W;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(COPY_N - 1);
    localparam logic [ADDR_W-1:0] ROW_START = ADDR_W'(COPY_N);
    localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    tcw_state_t state_reg, state_next;

    // item fields
    logic [FUNC_W-1:0]   func_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic [COL_IN_W-1:0] col_in_reg;
    logic [ROW_IN_W-1:0] row_in_reg;

    // cursor and control state
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0] cur_pos_reg, cur_pos_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [ATTR_W-1:0] text_color_reg;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              scroll_reg, scroll_next;

    // result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [POS_W-1:0]    rsp_pos_reg;
    logic [ROW_IN_W-1:0] rsp_row_reg;
    logic [COL_IN_W-1:0] rsp_col_reg;
    logic [CELL_W-1:0]   rsp_cell_reg;
    logic                rsp_scroll_reg;

    logic              accept;
    logic              rsp_load;
    logic              in_range;
    logic              is_newline;
    logic              wrap;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] scan_inc;
    logic [ADDR_W-1:0] scan_src;
    logic [PW-1:0]     pos_ext;
    logic [RW-1:0]     row_ext;
    logic [CW-1:0]     col_ext;

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign rsp_load   = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign in_range   = (32'(col_in_reg) < COLUMNS) && (32'(row_in_reg) < ROWS);
    assign is_newline = (code_reg == NEWLINE_CODE);
    assign wrap       = is_newline || (cur_col_reg == LAST_COL);
    assign cell_addr  = ADDR_W'(32'(row_in_reg) * COLUMNS + 32'(col_in_reg));

    // shared scan unit: sweeps the store for clear, copy and fill
    assign scan_inc = scan_reg + ADDR_W'(1);
    assign scan_src = scan_reg + COL_STEP;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (func_reg == FUNC_READ)
                begin
                    state_next = S_READ;
                end
                else if (func_reg == FUNC_PUT_CHAR && wrap && cur_row_reg == LAST_ROW)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:    state_next = S_DONE;
            S_COPY_RD: state_next = S_COPY_WR;
            S_COPY_WR:
            begin
                state_next = (scan_reg == LAST_COPY) ? S_FILL : S_COPY_RD;
            end
            S_FILL:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = scan_reg;
        mem_wdata      = BLANK_RESET;
        mem_raddr      = cell_addr;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_pos_next   = cur_pos_reg;
        scan_next      = scan_reg;
        cell_next      = cell_reg;
        scroll_next    = scroll_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_RESET;
                scan_next = (scan_reg == LAST_CELL) ? '0 : scan_inc;
            end
            S_EXEC:
            begin
                cell_next   = '0;
                scroll_next = 1'b0;
                unique case (func_reg)
                    FUNC_PUT_CHAR:
                    begin
                        mem_we    = !is_newline;
                        mem_waddr = cur_pos_reg;
                        mem_wdata = {text_color_reg, code_reg};
                        if (!wrap)
                        begin
                            cur_col_next = cur_col_reg + COL_W'(1);
                            cur_pos_next = cur_pos_reg + ADDR_W'(1);
                        end
                        else if (cur_row_reg == LAST_ROW)
                        begin
                            cur_col_next = '0;
                            cur_pos_next = ROW_START;
                            scroll_next  = 1'b1;
                            scan_next    = '0;
                        end
                        else
                        begin
                            cur_col_next = '0;
                            cur_row_next = cur_row_reg + ROW_W'(1);
                            cur_pos_next = cur_pos_reg - ADDR_W'(cur_col_reg) + COL_STEP;
                        end
                    end
                    FUNC_PUT_AT:
                    begin
                        mem_we    = in_range;
                        mem_waddr = cell_addr;
                        mem_wdata = {attr_reg, code_reg};
                    end
                    default:
                    begin
                        mem_raddr = cell_addr;
                    end
                endcase
            end
            S_READ:
            begin
                cell_next = in_range ? mem_rdata : '0;
            end
            S_COPY_RD:
            begin
                mem_raddr = scan_src;
            end
            S_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = mem_rdata;
                scan_next = scan_inc;
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = {text_color_reg, SPACE_CODE};
                scan_next = scan_inc;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // cursor values masked to the result field widths
    assign pos_ext = PW'(cur_pos_reg);
    assign row_ext = RW'(cur_row_reg);
    assign col_ext = CW'(cur_col_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            cur_pos_reg    <= '0;
            scan_reg       <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_pos_reg   <= cur_pos_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                text_color_reg <= cfg_wr_data;
            end
        end
    end

    // item capture, per-item results and output register
    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        scroll_reg <= scroll_next;
        if (accept)
        begin
            func_reg   <= cmd.func;
            code_reg   <= cmd.char_code;
            attr_reg   <= cmd.cell_color;
            col_in_reg <= cmd.column;
            row_in_reg <= cmd.row;
        end
        if (rsp_load)
        begin
            rsp_pos_reg    <= pos_ext[POS_W-1:0];
            rsp_row_reg    <= row_ext[ROW_IN_W-1:0];
            rsp_col_reg    <= col_ext[COL_IN_W-1:0];
            rsp_cell_reg   <= cell_reg;
            rsp_scroll_reg <= scroll_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cursor_position = rsp_pos_reg;
    assign rsp.cursor_row      = rsp_row_reg;
    assign rsp.cursor_col      = rsp_col_reg;
    assign rsp.cell_data       = rsp_cell_reg;
    assign rsp.scrolled        = rsp_scroll_reg;

endmodule

FILE: rtl/core/text_console_writer.sv
// channel | dir  | transaction payload
// --------+------+---------------------------------------------------------
// cmd     | in   | func, char_code, cell_color, column, row
// rsp     | out  | cursor_position, cursor_row, cursor_col, cell_data, scrolled
// cfg     | in   | cfg_wr_en / cfg_wr_data write the text_color register
//
// put-char and put-at go from accept through S_EXEC to S_DONE, where the
// result is registered; read adds S_READ for the registered read port of
// the screen store. a put-char that scrolls adds the copy sweep (a read and
// a write state per cell) and the blank fill.
// after reset a clearing pass writes all ROWS*COLUMNS cells, one per cycle,
// with cmd.ready low; cfg writes are taken throughout.
// a stalled rsp holds its result; the next cmd is accepted meanwhile.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data,
    tcw_cmd_if.sink                    cmd,
    tcw_rsp_if.source                  rsp
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // sequencer with cursor and scan unit
    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .rsp         (rsp),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // screen cell store
    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/core/tcw_checker.sv
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [tcw_pkg::POS_W-1:0]    rsp_cursor_position,
    input logic [tcw_pkg::ROW_IN_W-1:0] rsp_cursor_row,
    input logic [tcw_pkg::COL_IN_W-1:0] rsp_cursor_col,
    input logic                         rsp_scrolled
);
    import tcw_pkg::*;

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped while stalled");

    // a stalled result keeps its cursor position
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_cursor_position))
        else $error("rsp payload changed while stalled");

    // the block is busy in the cycle after a command is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd taken back to back");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_scrolled |->
            rsp_cursor_col == '0 && rsp_cursor_row == ROW_IN_W'(ROWS - 1))
        else $error("scroll left cursor off the bottom row start");

    // the cursor column never passes the row end
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_cursor_col) < COLUMNS)
        else $error("cursor column out of range");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_cursor_position (rsp.cursor_position),
    .rsp_cursor_row      (rsp.cursor_row),
    .rsp_cursor_col      (rsp.cursor_col),
    .rsp_scrolled        (rsp.scrolled)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int NCOL            = COLUMNS_DEF;
    localparam int NROW            = ROWS_DEF;
    localparam int NCELLS          = NCOL * NROW;
    localparam int CYCLE_LIMIT     = 16_000_000;
    localparam int TAIL_CYCLES     = 20;
    localparam int PRESSURE_CYCLES = 400;

    // unused function code, the block answers with the cursor only
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CODE_W-1:0]   code;
        logic [ATTR_W-1:0]   color;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
    } console_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [ROW_IN_W-1:0] crow;
        logic [COL_IN_W-1:0] ccol;
        logic [CELL_W-1:0]   word;
        logic                scrolled;
    } console_rsp_t;

    // screen mirror, cursor and color, plus the queue of pending cursor reports
    class console_scoreboard;
        logic [CELL_W-1:0] screen_mem [NCELLS];
        int                at_row;
        int                at_col;
        logic [ATTR_W-1:0] put_color;
        console_rsp_t      pending_reports [$];
        int unsigned       commands;
        int unsigned       checked;
        int unsigned       scrolls;
        int unsigned       mismatches;

        function new();
            foreach (screen_mem[i]) screen_mem[i] = BLANK_RESET;
            at_row     = 0;
            at_col     = 0;
            put_color  = TEXT_COLOR_RESET;
            commands   = 0;
            checked    = 0;
            scrolls    = 0;
            mismatches = 0;
        endfunction

        function void set_color(logic [ATTR_W-1:0] value);
            put_color = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // advance the mirror by one accepted command transaction
        function void apply_command(console_cmd_t c);
            console_rsp_t      report;
            logic [CELL_W-1:0] read_word;
            logic              did_scroll;
            logic              in_range;
            read_word  = '0;
            did_scroll = 1'b0;
            in_range   = (int'(c.col) < NCOL) && (int'(c.row) < NROW);
            commands++;
            case (c.func)
                FUNC_PUT_CHAR:
                begin
                    if (c.code == NEWLINE_CODE)
                    begin
                        at_row++;
                        at_col = 0;
                    end
                    else
                    begin
                        screen_mem[at_row * NCOL + at_col] = {put_color, c.code};
                        at_col++;
                        if (at_col >= NCOL)
                        begin
                            at_col = 0;
                            at_row++;
                        end
                    end
                    // past the bottom row: shift up and blank the last line
                    if (at_row >= NROW)
                    begin
                        for (int i = 0; i < NCOL * (NROW - 1); i++)
                            screen_mem[i] = screen_mem[i + NCOL];
                        for (int i = 0; i < NCOL; i++)
                            screen_mem[NCOL * (NROW - 1) + i] = {put_color, SPACE_CODE};
                        at_row     = NROW - 1;
                        did_scroll = 1'b1;
                        scrolls++;
                    end
                end
                FUNC_PUT_AT:
                begin
                    if (in_range)
                        screen_mem[int'(c.row) * NCOL + int'(c.col)] = {c.color, c.code};
                end
                FUNC_READ:
                begin
                    if (in_range)
                        read_word = screen_mem[int'(c.row) * NCOL + int'(c.col)];
                end
                default: ;
            endcase
            report.pos      = POS_W'(at_row * NCOL + at_col);
            report.crow     = ROW_IN_W'(at_row);
            report.ccol     = COL_IN_W'(at_col);
            report.word     = read_word;
            report.scrolled = did_scroll;
            pending_reports.push_back(report);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            end
        endfunction

        // compare one response transaction against the oldest pending report
        function void check_result(console_rsp_t got);
            console_rsp_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response expected none got 0x%0h",
                         $time, got);
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            compare_field("cursor_position", want.pos, got.pos);
            compare_field("cursor_row", want.crow, got.crow);
            compare_field("cursor_col", want.ccol, got.ccol);
            compare_field("cell_data", want.word, got.word);
            compare_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [ATTR_W-1:0] cfg_wr_data;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer #(
        .COLUMNS (NCOL),
        .ROWS    (NROW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch)
    );

    console_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int unsigned cycle_count = 0;
    int unsigned color_writes = 0;

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.cursor_position, rsp_ch.cursor_row,
                                 rsp_ch.cursor_col, rsp_ch.cell_data, rsp_ch.scrolled});
            if (cmd_ch.valid && cmd_ch.ready)
                sb.apply_command({cmd_ch.func, cmd_ch.char_code, cmd_ch.cell_color,
                                  cmd_ch.column, cmd_ch.row});
        end
    end

    // response side: random stalls, plus a long hold-off when requested
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one command and wait until it is taken
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] code,
                            input logic [ATTR_W-1:0] color, input int col, input int row);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.char_code  <= code;
        cmd_ch.cell_color <= color;
        cmd_ch.column     <= COL_IN_W'(col);
        cmd_ch.row        <= ROW_IN_W'(row);
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    endtask

    // stop offering and wait for every report to come back
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_color(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_color(value);
        color_writes++;
    endtask

    // corners of the fields, out-of-range cells, newline and the unused code
    task automatic run_directed();
        send_cmd(FUNC_READ, 8'h00, 8'h00, 0, 0);
        send_cmd(FUNC_READ, 8'h00, 8'h00, NCOL - 1, NROW - 1);
        send_cmd(FUNC_PUT_AT, 8'hFF, 8'hFF, NCOL - 1, NROW - 1);
        send_cmd(FUNC_READ, 8'h00, 8'h00, NCOL - 1, NROW - 1);
        send_cmd(FUNC_PUT_AT, 8'h00, 8'h00, 0, 0);
        send_cmd(FUNC_READ, 8'hFF, 8'hFF, 0, 0);
        send_cmd(FUNC_PUT_AT, 8'h55, 8'hAA, 127, 31);
        send_cmd(FUNC_PUT_AT, 8'hAA, 8'h55, NCOL, 0);
        send_cmd(FUNC_PUT_AT, 8'h41, 8'h1E, 0, NROW);
        send_cmd(FUNC_READ, 8'h00, 8'h00, 127, 31);
        send_cmd(FUNC_READ, 8'h00, 8'h00, NCOL, NROW - 1);
        send_cmd(FUNC_READ, 8'h00, 8'h00, NCOL - 1, NROW);
        send_cmd(FUNC_PUT_CHAR, 8'h41, 8'h00, 0, 0);
        send_cmd(FUNC_PUT_CHAR, 8'hFF, 8'hFF, 127, 31);
        send_cmd(FUNC_PUT_CHAR, 8'h00, 8'h00, 0, 0);
        send_cmd(FUNC_READ, 8'h00, 8'h00, 0, 0);
        send_cmd(FUNC_READ, 8'h00, 8'h00, 2, 0);
        send_cmd(FUNC_PUT_CHAR, NEWLINE_CODE, 8'h00, 0, 0);
        send_cmd(FUNC_NOP, 8'hFF, 8'hFF, 127, 31);
        send_cmd(FUNC_PUT_CHAR, NEWLINE_CODE, 8'hFF, 127, 31);
        send_cmd(FUNC_READ, 8'h00, 8'h00, 0, 1);
    endtask

    // bursts of text, newlines, cell writes with read-back, reads and noise
    task automatic random_traffic(input int n_items);
        int sent;
        int kind;
        int len;
        int col;
        int row;
        logic [CODE_W-1:0] code;
        logic [ATTR_W-1:0] color;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 25)
            begin
                // run of text, now and then a newline
                len = $urandom_range(1, 24);
                repeat (len)
                begin
                    code = ($urandom_range(99) < 5) ? NEWLINE_CODE : CODE_W'($urandom);
                    send_cmd(FUNC_PUT_CHAR, code, ATTR_W'($urandom),
                             $urandom_range(127), $urandom_range(31));
                    sent++;
                end
            end
            else if (kind < 33)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    send_cmd(FUNC_PUT_CHAR, NEWLINE_CODE, ATTR_W'($urandom),
                             $urandom_range(127), $urandom_range(31));
                    sent++;
                end
            end
            else if (kind < 55)
            begin
                // cell write, half the time read straight back
                col   = $urandom_range(NCOL - 1);
                row   = $urandom_range(NROW - 1);
                code  = CODE_W'($urandom);
                color = ATTR_W'($urandom);
                send_cmd(FUNC_PUT_AT, code, color, col, row);
                sent++;
                if ($urandom_range(1) == 1)
                begin
                    send_cmd(FUNC_READ, CODE_W'($urandom), ATTR_W'($urandom), col, row);
                    sent++;
                end
            end
            else if (kind < 85)
            begin
                // reads, half of them near the cursor to see text and scrolls
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    col = $urandom_range(NCOL - 1);
                    if ($urandom_range(1) == 1)
                    begin
                        row = sb.at_row - int'($urandom_range(2));
                        if (row < 0)
                            row = 0;
                    end
                    else
                        row = $urandom_range(NROW - 1);
                    send_cmd(FUNC_READ, CODE_W'($urandom), ATTR_W'($urandom), col, row);
                    sent++;
                end
            end
            else if (kind < 93)
            begin
                // cell outside the screen
                if ($urandom_range(1) == 1)
                begin
                    col = $urandom_range(127, NCOL);
                    row = $urandom_range(31);
                end
                else
                begin
                    col = $urandom_range(127);
                    row = $urandom_range(31, NROW);
                end
                send_cmd(($urandom_range(1) == 1) ? FUNC_PUT_AT : FUNC_READ,
                         CODE_W'($urandom), ATTR_W'($urandom), col, row);
                sent++;
            end
            else
            begin
                send_cmd(FUNC_NOP, CODE_W'($urandom), ATTR_W'($urandom),
                         $urandom_range(127), $urandom_range(31));
                sent++;
            end
        end
    endtask

    // reset, directed part, then three random phases with different stalls
    initial
    begin
        sb = new();
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = FUNC_PUT_CHAR;
        cmd_ch.char_code  = '0;
        cmd_ch.cell_color = '0;
        cmd_ch.column     = '0;
        cmd_ch.row        = '0;
        send_idle_pct     = 37;
        recv_idle_pct     = 53;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();

        write_color(8'h00);
        random_traffic(275);
        drain();

        send_idle_pct = 53;
        recv_idle_pct = 37;
        write_color(8'hFF);
        random_traffic(275);
        drain();

        // no idling, and the response side holds off at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_color(ATTR_W'($urandom_range(254, 1)));
        hold_left = PRESSURE_CYCLES;
        random_traffic(280);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d commands over directed corners and three stall mixes",
                 sb.commands);
        $display("%0d responses checked, %0d scrolls, %0d color writes, %0d mismatches",
                 sb.checked, sb.scrolls, color_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
